@@ rtl/mrm_pkg.sv @@
// Shared types, codes and the CRC helper for the Modbus RTU master block.
`timescale 1ns / 1ps
package mrm_pkg;

  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int RESP_BUF_BYTES_DEF = 48;
  localparam int MAX_WORDS_DEF      = 21;
  localparam int MAX_RESULTS        = 52;
  localparam int CNT_W              = $clog2(MAX_RESULTS + 1);
  localparam int CMDQ_DEPTH         = 2;
  localparam int CMDQ_AW            = $clog2(CMDQ_DEPTH);

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FN_EXC_BIT    = 8'h80;
  localparam logic [8:0]  RD_OVERHEAD   = 9'd5;
  localparam int          WR_FRAME_LEN  = 8;
  localparam int          EXC_FRAME_LEN = 5;

  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS = 8'd2;
  localparam logic [7:0] FC_READ_HOLD   = 8'd3;
  localparam logic [7:0] FC_READ_INREG  = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_RX      = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_POLL    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC      = 3'd1,
    ST_EXC      = 3'd2,
    ST_ECHO     = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_QUEUED   = 3'd5,
    ST_REJECTED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FS_NONE,
    FS_DONE,
    FS_DROP
  } frame_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POLL,
    S_CRC,
    S_REPLY,
    S_BCHK,
    S_BEM,
    S_WCHK,
    S_WHI,
    S_WLO,
    S_END,
    S_TO,
    S_SEL,
    S_TXC,
    S_TX,
    S_FIN
  } bk_state_e;

  typedef struct packed {
    action_e     op;
    logic        addr_zero;
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [15:0] start;
    logic [15:0] qty;
    logic [7:0]  rx;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  addr;
    logic [6:0]  fn;
    status_e     st;
    logic [15:0] val;
  } res_t;

  // One byte of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/modbus_rtu_master_transaction.sv @@
// Top level of the Modbus RTU master transaction block.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   action, addresses, quantity, rx byte
//   result   out        out_valid_o / out_stall_i kind, reply fields, status, value, last
//   config   in         cfg_we_i                  cfg_wdata_i (timeout in ms)
//
// Enqueue, received byte and tick requests pass through the execute and finish states of
// the back end. A poll checks the frame, runs a one-byte-per-cycle CRC walk over the
// response RAM and then emits the reply status or its data elements, each of which can
// stall on the output.
// The two-entry command queue keeps taking requests while the back end works or waits, until it is full.
// Reset is asynchronous and active low; there is no clearing pass.
// A stalled result holds in the output register while the next result waits behind it.
`timescale 1ns / 1ps
module modbus_rtu_master_transaction #(
  parameter int QUEUE_DEPTH    = mrm_pkg::QUEUE_DEPTH_DEF,
  parameter int RESP_BUF_BYTES = mrm_pkg::RESP_BUF_BYTES_DEF,
  parameter int MAX_WORDS      = mrm_pkg::MAX_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  slave_address_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] quantity_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  reply_address_o,
  output logic [6:0]  reply_function_o,
  output logic [2:0]  status_o,
  output logic [15:0] value_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import mrm_pkg::*;

  logic [15:0] timeout_q;
  cmd_t        push_data, head;
  logic        push, pop, q_full, q_empty;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  mrm_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .slave_address_i (slave_address_i),
    .function_code_i (function_code_i),
    .start_address_i (start_address_i),
    .quantity_i      (quantity_i),
    .rx_byte_i       (rx_byte_i),
    .q_full_i        (q_full),
    .q_push_o        (push),
    .q_data_o        (push_data)
  );

  mrm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  mrm_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .RESP_BUF_BYTES(RESP_BUF_BYTES),
    .MAX_WORDS     (MAX_WORDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .timeout_i  (timeout_q),
    .cmd_i      (head),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (res),
    .out_last_o (last_o)
  );

  assign kind_o           = res.kind;
  assign reply_address_o  = res.addr;
  assign reply_function_o = res.fn;
  assign status_o         = res.st;
  assign value_o          = res.val;

  // The command queue can never report full and empty together.
  a_fifo_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty)) else $error("command queue full and empty at once");

  // Transmit bytes and data elements always carry an ok status.
  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_STATUS |-> status_o == ST_OK)
    else $error("non-status result with nonzero status");

  // A transmit byte never has bits in the upper half of value.
  a_tx_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TX |-> value_o[15:8] == 8'h00)
    else $error("transmit byte wider than eight bits");

  // A queued or rejected answer is always the only result of its request.
  a_enq_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_QUEUED || status_o == ST_REJECTED) |-> last_o)
    else $error("enqueue answer not marked last");
endmodule

@@ rtl/mrm_ram.sv @@
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module mrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/mrm_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module mrm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrm_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output mrm_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import mrm_pkg::*;

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CMDQ_AW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ((wptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1) : wptr_q;
    rptr_d = do_pop ? ((rptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q + (CMDQ_AW + 1)'(do_push) - (CMDQ_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end
endmodule

@@ rtl/mrm_front.sv @@
// Front end: accepts input requests, classifies them and packs queue commands.
`timescale 1ns / 1ps
module mrm_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  logic [7:0]    slave_address_i,
  input  logic [7:0]    function_code_i,
  input  logic [15:0]   start_address_i,
  input  logic [15:0]   quantity_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output mrm_pkg::cmd_t q_data_o
);
  import mrm_pkg::*;

  always_comb begin
    q_data_o = '0;
    case (action_i)
      ACT_ENQUEUE: begin
        q_data_o.op        = ACT_ENQUEUE;
        q_data_o.addr_zero = (slave_address_i == 8'h00);
        q_data_o.addr      = slave_address_i;
        q_data_o.fn        = function_code_i;
        q_data_o.start     = start_address_i;
        q_data_o.qty       = quantity_i;
      end
      ACT_RX: begin
        q_data_o.op = ACT_RX;
        q_data_o.rx = rx_byte_i;
      end
      ACT_TICK: q_data_o.op = ACT_TICK;
      default:  q_data_o.op = ACT_POLL;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
endmodule

@@ rtl/mrm_back.sv @@
// Back end: request slots, response buffer, frame checks, transmit and results.
`timescale 1ns / 1ps
module mrm_back #(
  parameter int QUEUE_DEPTH    = mrm_pkg::QUEUE_DEPTH_DEF,
  parameter int RESP_BUF_BYTES = mrm_pkg::RESP_BUF_BYTES_DEF,
  parameter int MAX_WORDS      = mrm_pkg::MAX_WORDS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   timeout_i,
  input  mrm_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mrm_pkg::res_t out_res_o,
  output logic          out_last_o
);
  import mrm_pkg::*;

  localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(RESP_BUF_BYTES + 1);
  localparam int AW = $clog2(RESP_BUF_BYTES);
  localparam int PW = $clog2(RESP_BUF_BYTES + 3);

  bk_state_e state_q, state_d;
  cmd_t      cmd_q;

  logic [7:0]  qaddr_q [QUEUE_DEPTH];
  logic        qrdy_q  [QUEUE_DEPTH];
  logic [7:0]  qfn_q   [QUEUE_DEPTH];
  logic [15:0] qst_q   [QUEUE_DEPTH];
  logic [15:0] qqt_q   [QUEUE_DEPTH];

  logic          busy_q;
  logic [SW-1:0] cur_q;
  logic [LW-1:0] len_q, k_q;
  logic [31:0]   ms_q, sent_q;
  logic [7:0]    hdr_q [6];
  logic [15:0]   crc_q;
  logic [7:0]    i_q, hi_q;
  logic [PW-1:0] p_q;
  logic [2:0]    j_q;
  logic [CNT_W-1:0] cnt_q;
  logic          pend_v_q, out_v_q, out_last_q;
  res_t          pend_q, out_q;

  logic          free_found, rdy_found;
  logic [SW-1:0] free_idx, rdy_idx;
  logic [7:0]    fn_b, b2;
  frame_e        fs;
  logic          is_rd_bytes, is_rd_words, expired, enq_ok;
  logic [7:0]    nw, tx_byte, ram_rdata;
  logic [AW-1:0] raddr;
  logic          ram_we;
  logic          emit_v, fire, push, cap, out_free, out_load, end_tr, start_tx;
  res_t          emit_r;
  logic          byte_go, word_go;
  logic [31:0]   elapsed;

  assign fn_b = hdr_q[1];
  assign b2   = hdr_q[2];
  assign is_rd_bytes = (fn_b == FC_READ_COILS) || (fn_b == FC_READ_INPUTS);
  assign is_rd_words = (fn_b == FC_READ_HOLD) || (fn_b == FC_READ_INREG);
  assign nw = ((b2 >> 1) > 8'(MAX_WORDS)) ? 8'(MAX_WORDS) : (b2 >> 1);
  assign elapsed = ms_q - sent_q;
  assign expired = busy_q && (elapsed > {16'h0000, timeout_i});
  assign enq_ok  = !cmd_q.addr_zero && free_found;
  assign byte_go = (i_q < b2) && (p_q < PW'(len_q));
  assign word_go = (i_q < nw) && ((p_q + 1'b1) < PW'(len_q));

  // Lowest-numbered free slot and lowest-numbered ready slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    rdy_found  = 1'b0;
    rdy_idx    = '0;
    for (int s = QUEUE_DEPTH - 1; s >= 0; s--) begin
      if (qaddr_q[s] == 8'h00) begin
        free_found = 1'b1;
        free_idx   = SW'(s);
      end
      if (qaddr_q[s] != 8'h00 && qrdy_q[s]) begin
        rdy_found = 1'b1;
        rdy_idx   = SW'(s);
      end
    end
  end

  always_comb begin
    fs = FS_NONE;
    if (busy_q && len_q > LW'(4) && hdr_q[0] == qaddr_q[cur_q]) begin
      if ((fn_b & FN_EXC_BIT) != 8'h00 && len_q == LW'(EXC_FRAME_LEN)) begin
        fs = FS_DONE;
      end else if (is_rd_bytes || is_rd_words) begin
        fs = (9'(len_q) == ({1'b0, b2} + RD_OVERHEAD)) ? FS_DONE : FS_NONE;
      end else if (fn_b == FC_WRITE_COIL || fn_b == FC_WRITE_REG ||
                   fn_b == FC_WRITE_COILS || fn_b == FC_WRITE_REGS) begin
        fs = (len_q == LW'(WR_FRAME_LEN)) ? FS_DONE : FS_NONE;
      end else begin
        fs = FS_DROP;
      end
    end
  end

  always_comb begin
    case (j_q)
      3'd0:    tx_byte = qaddr_q[cur_q];
      3'd1:    tx_byte = qfn_q[cur_q];
      3'd2:    tx_byte = qst_q[cur_q][15:8];
      3'd3:    tx_byte = qst_q[cur_q][7:0];
      3'd4:    tx_byte = qqt_q[cur_q][15:8];
      3'd5:    tx_byte = qqt_q[cur_q][7:0];
      3'd6:    tx_byte = crc_q[7:0];
      default: tx_byte = crc_q[15:8];
    endcase
  end

  assign ram_we = (state_q == S_EXEC) && (cmd_q.op == ACT_RX) && busy_q &&
                  (len_q < LW'(RESP_BUF_BYTES));

  mrm_ram #(
    .WIDTH(8),
    .DEPTH(RESP_BUF_BYTES)
  ) u_resp_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(len_q)),
    .wdata_i(cmd_q.rx),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Result generation and buffer read address.
  always_comb begin
    emit_v      = 1'b0;
    emit_r      = '0;
    emit_r.kind = KIND_STATUS;
    emit_r.st   = ST_OK;
    emit_r.addr = qaddr_q[cur_q];
    emit_r.fn   = fn_b[6:0];
    raddr       = AW'(p_q);
    case (state_q)
      S_EXEC: begin
        if (cmd_q.op == ACT_ENQUEUE) begin
          emit_v      = 1'b1;
          emit_r.addr = cmd_q.addr;
          emit_r.fn   = cmd_q.fn[6:0];
          emit_r.st   = enq_ok ? ST_QUEUED : ST_REJECTED;
        end
      end
      S_CRC: raddr = AW'(k_q);
      S_REPLY: begin
        if (crc_q != 16'h0000) begin
          emit_v    = 1'b1;
          emit_r.st = ST_CRC;
          emit_r.fn = qfn_q[cur_q][6:0];
        end else if ((fn_b & FN_EXC_BIT) != 8'h00) begin
          emit_v     = 1'b1;
          emit_r.st  = ST_EXC;
          emit_r.val = {8'h00, b2};
        end else if (!is_rd_bytes && !is_rd_words) begin
          emit_v    = 1'b1;
          emit_r.st = ({hdr_q[2], hdr_q[3]} != qst_q[cur_q] ||
                       {hdr_q[4], hdr_q[5]} != qqt_q[cur_q]) ? ST_ECHO : ST_OK;
        end
      end
      S_BEM: begin
        emit_v      = 1'b1;
        emit_r.kind = KIND_DATA;
        emit_r.val  = {8'h00, ram_rdata};
      end
      S_WHI: raddr = AW'(p_q + 1'b1);
      S_WLO: begin
        raddr       = AW'(p_q + 1'b1);
        emit_v      = 1'b1;
        emit_r.kind = KIND_DATA;
        emit_r.val  = {hi_q, ram_rdata};
      end
      S_TO: begin
        if (expired) begin
          emit_v    = 1'b1;
          emit_r.st = ST_TIMEOUT;
          emit_r.fn = qfn_q[cur_q][6:0];
        end
      end
      S_TX: begin
        emit_v      = 1'b1;
        emit_r.kind = KIND_TX;
        emit_r.fn   = qfn_q[cur_q][6:0];
        emit_r.val  = {8'h00, tx_byte};
      end
      default: ;
    endcase
  end

  // The newest result is held back one step so that its last flag is known.
  assign out_free = !out_v_q || !out_stall_i;
  assign cap      = (cnt_q >= CNT_W'(MAX_RESULTS));
  assign fire     = emit_v && (cap || !pend_v_q || out_free);
  assign push     = fire && !cap;
  assign out_load = (push && pend_v_q) || ((state_q == S_FIN) && pend_v_q && out_free);
  assign end_tr   = ((state_q == S_POLL) && fs == FS_DROP) || (state_q == S_END) ||
                    ((state_q == S_TO) && expired && fire);
  assign start_tx = (state_q == S_SEL) && !busy_q && rdy_found;
  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!cmd_empty_i) state_d = S_EXEC;
      S_EXEC: begin
        case (cmd_q.op)
          ACT_ENQUEUE: if (fire) state_d = S_FIN;
          ACT_POLL:    state_d = S_POLL;
          default:     state_d = S_FIN;
        endcase
      end
      S_POLL: begin
        case (fs)
          FS_DONE: state_d = S_CRC;
          default: state_d = S_TO;
        endcase
      end
      S_CRC: if (k_q == len_q) state_d = S_REPLY;
      S_REPLY: begin
        if (emit_v) begin
          if (fire) state_d = S_END;
        end else if (is_rd_bytes) begin
          state_d = S_BCHK;
        end else begin
          state_d = S_WCHK;
        end
      end
      S_BCHK:  state_d = byte_go ? S_BEM : S_END;
      S_BEM:   if (fire) state_d = S_BCHK;
      S_WCHK:  state_d = word_go ? S_WHI : S_END;
      S_WHI:   state_d = S_WLO;
      S_WLO:   if (fire) state_d = S_WCHK;
      S_END:   state_d = S_TO;
      S_TO:    if (!expired || fire) state_d = S_SEL;
      S_SEL:   state_d = start_tx ? S_TXC : S_FIN;
      S_TXC:   if (j_q == 3'd5) state_d = S_TX;
      S_TX:    if (fire && j_q == 3'd7) state_d = S_FIN;
      S_FIN:   if (!pend_v_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      busy_q     <= 1'b0;
      cur_q      <= '0;
      len_q      <= '0;
      ms_q       <= '0;
      sent_q     <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      k_q        <= '0;
      i_q        <= '0;
      p_q        <= '0;
      j_q        <= '0;
      crc_q      <= CRC_INIT;
      for (int s = 0; s < QUEUE_DEPTH; s++) begin
        qaddr_q[s] <= 8'h00;
        qrdy_q[s]  <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      out_v_q <= out_load ? 1'b1 : (out_v_q && out_stall_i);
      if (push) begin
        pend_v_q <= 1'b1;
        cnt_q    <= cnt_q + 1'b1;
      end else if (state_q == S_FIN && out_free) begin
        pend_v_q <= 1'b0;
      end
      if (state_q == S_IDLE) begin
        cnt_q <= '0;
      end
      if (state_q == S_EXEC && cmd_q.op == ACT_TICK) begin
        ms_q <= ms_q + 32'd1;
      end
      if (ram_we) begin
        len_q <= len_q + 1'b1;
      end
      if (state_q == S_EXEC && cmd_q.op == ACT_ENQUEUE && fire && enq_ok) begin
        qaddr_q[free_idx] <= cmd_q.addr;
        qrdy_q[free_idx]  <= 1'b1;
      end
      if (state_q == S_POLL) begin
        k_q   <= '0;
        crc_q <= CRC_INIT;
      end
      if (state_q == S_CRC) begin
        if (k_q != '0) crc_q <= crc16_byte(crc_q, ram_rdata);
        if (k_q != len_q) k_q <= k_q + 1'b1;
      end
      if (state_q == S_REPLY) begin
        i_q <= '0;
        p_q <= PW'(3);
      end
      if (state_q == S_BEM && fire) begin
        i_q <= i_q + 1'b1;
        p_q <= p_q + 1'b1;
      end
      if (state_q == S_WLO && fire) begin
        i_q <= i_q + 1'b1;
        p_q <= p_q + PW'(2);
      end
      if (end_tr) begin
        qaddr_q[cur_q] <= 8'h00;
        qrdy_q[cur_q]  <= 1'b0;
        busy_q         <= 1'b0;
        len_q          <= '0;
        sent_q         <= '0;
      end
      if (start_tx) begin
        qrdy_q[rdy_idx] <= 1'b0;
        busy_q          <= 1'b1;
        cur_q           <= rdy_idx;
        len_q           <= '0;
        sent_q          <= ms_q;
        j_q             <= '0;
        crc_q           <= CRC_INIT;
      end
      if (state_q == S_TXC) begin
        crc_q <= crc16_byte(crc_q, tx_byte);
        j_q   <= (j_q == 3'd5) ? 3'd0 : j_q + 1'b1;
      end
      if (state_q == S_TX && fire) begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_EXEC && cmd_q.op == ACT_ENQUEUE && fire && enq_ok) begin
      qfn_q[free_idx] <= cmd_q.fn;
      qst_q[free_idx] <= cmd_q.start;
      qqt_q[free_idx] <= cmd_q.qty;
    end
    if (ram_we && len_q < LW'(6)) begin
      hdr_q[len_q[2:0]] <= cmd_q.rx;
    end
    if (state_q == S_WHI) begin
      hi_q <= ram_rdata;
    end
    if (push) begin
      pend_q <= emit_r;
    end
    if (out_load) begin
      out_q      <= pend_q;
      out_last_q <= (state_q == S_FIN);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;
endmodule
